### sv/scr_pkg.sv
`timescale 1ns / 1ps
package scr_pkg;

	localparam int ENTRIES        = 32;
	localparam int REF_BITS       = 16;
	localparam int KEY_W          = 64;
	localparam int BYTES_W        = 32;
	localparam int BUDGET_W       = 48;
	localparam int OVH_W          = 12;
	localparam int LINK_W         = 6;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 48;
	localparam int OVERHEAD_RESET = 128;

	localparam logic [LINK_W-1:0] NIL = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 2'd1;

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_PUT   = 2'd1,
		OP_FIXUP = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		KIND_FINAL   = 1'b0,
		KIND_RELEASE = 1'b1
	} kind_t;

	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_W-1:0]    key_high;
		logic [KEY_W-1:0]    key_low;
		logic [KEY_W-1:0]    aux_key;
		logic [KEY_W-1:0]    new_aux_key;
		logic [REF_BITS-1:0] data_ref;
		logic [BYTES_W-1:0]  data_bytes;
	} cmd_t;

	typedef struct packed {
		logic                kind;
		logic                found;
		logic [REF_BITS-1:0] ref_out;
		logic [BYTES_W-1:0]  released_bytes;
		logic                last;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key_high;
		logic [KEY_W-1:0]    key_low;
		logic [KEY_W-1:0]    aux;
		logic [REF_BITS-1:0] ref_v;
		logic [BYTES_W-1:0]  size;
	} rec_t;

endpackage

### sv/scr_ram.sv
`timescale 1ns / 1ps
module scr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/sieve_cache_replacement_unit.sv
`timescale 1ns / 1ps
// Disabled or unknown requests answer in the cycle after start; get/fixup walk the entries
// from newest to oldest until a match or the end of the walk. A put also releases stale
// entries on the walk, then evicts with hand steps and budget checks, scans for a free slot
// and links the entry. One request at a time.
// Release reports come one per released entry ahead of the final answer; the receiver cannot stall.
// Reset: empty directory, budget 0 (cache disabled), entry overhead 128.
module sieve_cache_replacement_unit #(
	parameter int ENTRIES = scr_pkg::ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  scr_pkg::cmd_t                    cmd,
	output logic                             result_valid,
	output scr_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [scr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int STEP_W   = $clog2(2 * ENTRIES + 3);
	localparam int LINK_W   = scr_pkg::LINK_W;
	localparam int BUDGET_W = scr_pkg::BUDGET_W;
	localparam int BYTES_W  = scr_pkg::BYTES_W;
	localparam int OVH_W    = scr_pkg::OVH_W;
	localparam int REC_W    = $bits(scr_pkg::rec_t);

	localparam logic [LINK_W-1:0] ENT_L     = LINK_W'(ENTRIES);
	localparam logic [STEP_W-1:0] SRCH_LIM  = STEP_W'(ENTRIES);
	localparam logic [STEP_W-1:0] SWEEP_LIM = STEP_W'(2 * ENTRIES + 2);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_RD,
		ST_S_CHK,
		ST_REL,
		ST_EV_CHK,
		ST_EV_SW,
		ST_EV_NX,
		ST_FIND,
		ST_INS_W,
		ST_INS_L
	} state_t;

	state_t               state_q;
	scr_pkg::cmd_t        cmd_q;
	logic [BUDGET_W-1:0]  budget_q;
	logic [OVH_W-1:0]     ovh_q;
	logic [LINK_W-1:0]    head_q, tail_q, hand_q, e_q;
	logic [BUDGET_W-1:0]  used_q;
	logic [LINK_W-1:0]    count_q, guard_q;
	logic [STEP_W-1:0]    steps_q;
	logic [IDX_W-1:0]     scan_q;
	logic                 evict_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [ENTRIES-1:0]   visited_q;
	logic                 res_valid_q;
	scr_pkg::result_t     res_q;

	scr_pkg::rec_t        rec_rd, rec_wd;
	logic [LINK_W-1:0]    next_rd, prev_rd, next_wd, prev_wd;
	logic [IDX_W-1:0]     rec_wa, next_wa, prev_wa, e_idx;
	logic                 rec_we, next_we, prev_we;

	logic [BYTES_W:0]     need;
	logic [BUDGET_W:0]    sum_need;
	logic [BYTES_W:0]     charge;
	logic                 key_hit, aux_hit, e_ok, pv_ok, nx_ok, tail_ok, hand_ok, over;

	assign e_idx   = e_q[IDX_W-1:0];
	assign e_ok    = e_q < ENT_L;
	assign pv_ok   = prev_rd < ENT_L;
	assign nx_ok   = next_rd < ENT_L;
	assign tail_ok = tail_q < ENT_L;
	assign hand_ok = hand_q < ENT_L;
	assign key_hit = valid_q[e_idx] && rec_rd.key_high == cmd_q.key_high
		&& rec_rd.key_low == cmd_q.key_low;
	assign aux_hit = rec_rd.aux == cmd_q.aux_key;
	assign need     = {1'b0, BYTES_W'(ovh_q)} + {1'b0, cmd_q.data_bytes};
	assign sum_need = {1'b0, used_q} + (BUDGET_W + 1)'(need);
	assign charge   = {1'b0, BYTES_W'(ovh_q)} + {1'b0, rec_rd.size};
	assign over     = (sum_need > {1'b0, budget_q} || count_q >= ENT_L)
		&& count_q != '0 && guard_q < ENT_L;

	assign busy         = state_q != ST_IDLE;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		rec_we  = 1'b0;
		rec_wa  = e_idx;
		rec_wd  = rec_rd;
		next_we = 1'b0;
		next_wa = prev_rd[IDX_W-1:0];
		next_wd = next_rd;
		prev_we = 1'b0;
		prev_wa = next_rd[IDX_W-1:0];
		prev_wd = prev_rd;
		unique case (state_q)
			ST_S_CHK: begin
				if (scr_pkg::op_t'(cmd_q.op) == scr_pkg::OP_FIXUP && key_hit && aux_hit) begin
					rec_we     = 1'b1;
					rec_wd.aux = cmd_q.new_aux_key;
				end
			end
			ST_REL: begin
				next_we = pv_ok;
				prev_we = nx_ok;
			end
			ST_INS_W: begin
				rec_we  = 1'b1;
				rec_wa  = scan_q;
				rec_wd  = '{key_high: cmd_q.key_high, key_low: cmd_q.key_low,
					aux: cmd_q.aux_key, ref_v: cmd_q.data_ref, size: cmd_q.data_bytes};
				next_we = 1'b1;
				next_wa = scan_q;
				next_wd = scr_pkg::NIL;
				prev_we = 1'b1;
				prev_wa = scan_q;
				prev_wd = tail_q;
			end
			ST_INS_L: begin
				next_we = tail_ok;
				next_wa = tail_q[IDX_W-1:0];
				next_wd = LINK_W'(scan_q);
			end
			default: begin
			end
		endcase
	end

	scr_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
		.raddr(e_idx), .rdata(rec_rd)
	);

	scr_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(e_idx), .rdata(next_rd)
	);

	scr_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(e_idx), .rdata(prev_rd)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_S_CHK && key_hit && aux_hit
			&& scr_pkg::op_t'(cmd_q.op) != scr_pkg::OP_FIXUP) begin
			visited_q[e_idx] <= 1'b1;
		end
		if (state_q == ST_EV_SW && e_ok && visited_q[e_idx] && steps_q < SWEEP_LIM) begin
			visited_q[e_idx] <= 1'b0;
		end
		if (state_q == ST_INS_L) begin
			visited_q[scan_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			budget_q    <= '0;
			ovh_q       <= OVH_W'(scr_pkg::OVERHEAD_RESET);
			head_q      <= scr_pkg::NIL;
			tail_q      <= scr_pkg::NIL;
			hand_q      <= scr_pkg::NIL;
			e_q         <= scr_pkg::NIL;
			used_q      <= '0;
			count_q     <= '0;
			guard_q     <= '0;
			steps_q     <= '0;
			scan_q      <= '0;
			evict_q     <= 1'b0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == scr_pkg::CFG_BUDGET) begin
					budget_q <= cfg_data[BUDGET_W-1:0];
				end else if (cfg_index == scr_pkg::CFG_OVERHEAD) begin
					ovh_q <= cfg_data[OVH_W-1:0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (budget_q == '0 || scr_pkg::op_t'(cmd.op) == scr_pkg::OP_NONE) begin
							res_valid_q <= 1'b1;
							res_q       <= '{kind: scr_pkg::KIND_FINAL, found: 1'b0,
								ref_out: '0, released_bytes: '0, last: 1'b1};
						end else begin
							e_q     <= tail_q;
							steps_q <= '0;
							evict_q <= 1'b0;
							state_q <= ST_S_RD;
						end
					end
				end
				ST_S_RD: begin
					if (!e_ok || steps_q == SRCH_LIM) begin
						if (scr_pkg::op_t'(cmd_q.op) == scr_pkg::OP_PUT) begin
							guard_q <= '0;
							state_q <= ST_EV_CHK;
						end else begin
							res_valid_q <= 1'b1;
							res_q       <= '{kind: scr_pkg::KIND_FINAL, found: 1'b0,
								ref_out: '0, released_bytes: '0, last: 1'b1};
							state_q     <= ST_IDLE;
						end
					end else begin
						state_q <= ST_S_CHK;
					end
				end
				ST_S_CHK: begin
					if (key_hit && aux_hit) begin
						res_valid_q <= 1'b1;
						res_q       <= '{kind: scr_pkg::KIND_FINAL, found: 1'b1,
							ref_out: (scr_pkg::op_t'(cmd_q.op) == scr_pkg::OP_GET)
								? rec_rd.ref_v : '0,
							released_bytes: '0, last: 1'b1};
						state_q     <= ST_IDLE;
					end else if (key_hit && scr_pkg::op_t'(cmd_q.op) == scr_pkg::OP_PUT) begin
						state_q <= ST_REL;
					end else begin
						e_q     <= prev_rd;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_REL: begin
					if (evict_q || hand_q == e_q) begin
						hand_q <= next_rd;
					end
					if (!pv_ok) begin
						head_q <= next_rd;
					end
					if (!nx_ok) begin
						tail_q <= prev_rd;
					end
					valid_q[e_idx] <= 1'b0;
					if (count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
					used_q <= ({1'b0, used_q} > (BUDGET_W + 1)'(charge))
						? used_q - BUDGET_W'(charge) : '0;
					res_valid_q <= 1'b1;
					res_q       <= '{kind: scr_pkg::KIND_RELEASE, found: 1'b0,
						ref_out: rec_rd.ref_v, released_bytes: rec_rd.size, last: 1'b0};
					if (evict_q) begin
						guard_q <= guard_q + 1'b1;
						state_q <= ST_EV_CHK;
					end else begin
						e_q     <= prev_rd;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_EV_CHK: begin
					if (over) begin
						e_q     <= hand_ok ? hand_q : head_q;
						steps_q <= '0;
						evict_q <= 1'b1;
						state_q <= ST_EV_SW;
					end else begin
						scan_q  <= '0;
						state_q <= ST_FIND;
					end
				end
				ST_EV_SW: begin
					if (!e_ok) begin
						guard_q <= guard_q + 1'b1;
						state_q <= ST_EV_CHK;
					end else if (visited_q[e_idx] && steps_q < SWEEP_LIM) begin
						state_q <= ST_EV_NX;
					end else begin
						state_q <= ST_REL;
					end
				end
				ST_EV_NX: begin
					e_q     <= nx_ok ? next_rd : head_q;
					steps_q <= steps_q + 1'b1;
					state_q <= ST_EV_SW;
				end
				ST_FIND: begin
					if (!valid_q[scan_q]) begin
						state_q <= ST_INS_W;
					end else if (scan_q == LAST_IDX) begin
						res_valid_q <= 1'b1;
						res_q       <= '{kind: scr_pkg::KIND_FINAL, found: 1'b0,
							ref_out: '0, released_bytes: '0, last: 1'b1};
						state_q     <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_INS_W: begin
					state_q <= ST_INS_L;
				end
				ST_INS_L: begin
					if (!tail_ok) begin
						head_q <= LINK_W'(scan_q);
					end
					tail_q          <= LINK_W'(scan_q);
					valid_q[scan_q] <= 1'b1;
					used_q          <= sum_need[BUDGET_W-1:0];
					count_q         <= count_q + 1'b1;
					res_valid_q     <= 1'b1;
					res_q           <= '{kind: scr_pkg::KIND_FINAL, found: 1'b1,
						ref_out: '0, released_bytes: '0, last: 1'b1};
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/scr_checker.sv
`timescale 1ns / 1ps
module scr_assertions (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_valid,
	input scr_pkg::result_t result
);

	// final answer closes the transaction
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("final answer while busy");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || (result_valid && result.last))
		else $error("accepted transaction neither running nor answered");

	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy && result.kind == scr_pkg::KIND_RELEASE)
		else $error("release report outside a running put");

	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == scr_pkg::KIND_FINAL |-> result.last)
		else $error("final answer without last");

	a_report_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == scr_pkg::KIND_RELEASE |-> !result.found)
		else $error("release report with found");

endmodule

bind sieve_cache_replacement_unit scr_assertions u_scr_assertions (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.result_valid(result_valid),
	.result(result)
);
